// File: src/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg: shared types and microcode for the format print engine
// Character codes, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package fpe_pkg;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  // What a step puts on the output channel
  typedef enum logic [2:0] {
    EM_NONE,
    EM_FMT,
    EM_ARG,
    EM_MINUS,
    EM_DIGIT
  } emit_e;

  // How the last flag is formed
  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_DIGIT
  } last_e;

  // Datapath operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_POP
  } dp_op_e;

  // Next step rule
  typedef enum logic [2:0] {
    J_ALWAYS,
    J_DISPATCH,
    J_OUT,
    J_CONV,
    J_SIGN,
    J_SKIP,
    J_DIGIT
  } jump_e;

  typedef logic [2:0] upc_t;

  localparam int unsigned UPC_N = 8;

  localparam upc_t UPC_WAIT  = 3'd0;
  localparam upc_t UPC_ECHO  = 3'd1;
  localparam upc_t UPC_ARGB  = 3'd2;
  localparam upc_t UPC_CONV  = 3'd3;
  localparam upc_t UPC_SIGN  = 3'd4;
  localparam upc_t UPC_SKIP  = 3'd5;
  localparam upc_t UPC_DIGIT = 3'd6;

  typedef struct packed {
    emit_e  emit;
    last_e  last;
    dp_op_e op;
    jump_e  jump;
    upc_t   target;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    dp_op_e op;
    emit_e  emit;
  } dp_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic top_zero;
    logic one_left;
  } dp_stat_t;

  // Sequencer program
  localparam ucode_t UCODE [UPC_N] = '{
    '{EM_NONE,  LAST_NO,    OP_LOAD,   J_DISPATCH, UPC_WAIT},  // wait for an item
    '{EM_FMT,   LAST_YES,   OP_NONE,   J_OUT,      UPC_WAIT},  // echo format byte
    '{EM_ARG,   LAST_YES,   OP_NONE,   J_OUT,      UPC_WAIT},  // argument low byte
    '{EM_NONE,  LAST_NO,    OP_DABBLE, J_CONV,     UPC_SIGN},  // binary to BCD
    '{EM_MINUS, LAST_NO,    OP_NONE,   J_SIGN,     UPC_SKIP},  // optional minus
    '{EM_NONE,  LAST_NO,    OP_SKIP,   J_SKIP,     UPC_DIGIT}, // drop leading zeros
    '{EM_DIGIT, LAST_DIGIT, OP_POP,    J_DIGIT,    UPC_WAIT},  // digits out
    '{EM_NONE,  LAST_NO,    OP_NONE,   J_ALWAYS,   UPC_WAIT}   // spare
  };

endpackage

// File: src/fpe_datapath.sv
// ----------------------------------------------------------------------------
// fpe_datapath: operand registers and decimal converter
// Holds the captured item, converts the magnitude to BCD four bits per
// cycle and shifts digits out most significant first.
// ----------------------------------------------------------------------------
module fpe_datapath #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic [7:0]            fmt_char_i,
  input  logic [ARG_WIDTH-1:0]  arg_value_i,
  input  fpe_pkg::dp_ctrl_t     ctrl_i,
  output fpe_pkg::dp_stat_t     stat_o,
  output logic [7:0]            out_char_o
);
  import fpe_pkg::*;

  // Decimal digits needed for the largest magnitude, 2^(ARG_WIDTH-1)
  function automatic int dec_digits(int w);
    longint unsigned v;
    int n;
    v = 64'd1 << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / 10;
        n++;
      end
    end
    return n;
  endfunction

  localparam int NDIG   = dec_digits(ARG_WIDTH);
  localparam int BCD_W  = 4 * NDIG;
  localparam int MAG_W  = ((ARG_WIDTH + 3) / 4) * 4;
  localparam int STEPS  = MAG_W / 4;
  localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int LEFT_W = $clog2(NDIG + 1);

  logic [7:0]       fmt_q;
  logic [7:0]       argb_q;
  logic             neg_q;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEFT_W-1:0] left_q, left_d;

  logic [ARG_WIDTH-1:0]   abs_val;
  logic [BCD_W+MAG_W-1:0] sh;
  logic [3:0]             dg;

  // Magnitude in unsigned arithmetic, correct for the most negative value
  assign abs_val = arg_value_i[ARG_WIDTH-1] ? (~arg_value_i + 1'b1) : arg_value_i;

  // Four shift-and-add-3 steps per cycle
  always_comb begin
    sh = {bcd_q, mag_q};
    dg = 4'd0;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        dg = sh[MAG_W+4*d +: 4];
        if (dg >= 4'd5) begin
          sh[MAG_W+4*d +: 4] = dg + 4'd3;
        end
      end
      sh = sh << 1;
    end
  end

  // Next values per operation
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    left_d = left_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        mag_d  = MAG_W'(abs_val);
        bcd_d  = '0;
        cnt_d  = CNT_W'(STEPS - 1);
        left_d = LEFT_W'(NDIG);
      end
      OP_DABBLE: begin
        bcd_d = sh[BCD_W+MAG_W-1:MAG_W];
        mag_d = sh[MAG_W-1:0];
        cnt_d = cnt_q - 1'b1;
      end
      OP_SKIP, OP_POP: begin
        bcd_d  = bcd_q << 4;
        left_d = left_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      fmt_q  <= fmt_char_i;
      argb_q <= arg_value_i[7:0];
      neg_q  <= arg_value_i[ARG_WIDTH-1];
    end
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    left_q <= left_d;
  end

  // Status back to the sequencer
  assign stat_o.conv_done = (cnt_q == '0);
  assign stat_o.neg       = neg_q;
  assign stat_o.top_zero  = (bcd_q[BCD_W-1 -: 4] == 4'd0);
  assign stat_o.one_left  = (left_q == LEFT_W'(1));

  // Output character select
  always_comb begin
    case (ctrl_i.emit)
      EM_FMT:   out_char_o = fmt_q;
      EM_ARG:   out_char_o = argb_q;
      EM_MINUS: out_char_o = CH_MINUS;
      EM_DIGIT: out_char_o = CH_ZERO | {4'd0, bcd_q[BCD_W-1 -: 4]};
      default:  out_char_o = 8'd0;
    endcase
  end

endmodule

// File: src/format_print_engine_top.sv
// ----------------------------------------------------------------------------
// format_print_engine_top: format string printer, one byte per item
// Microcoded sequencer in front of a small conversion datapath.
// ----------------------------------------------------------------------------
// Plain byte, %% and %c: the item is accepted, then one output character is sent.
// '%' alone and unknown specifiers: accepted, no output.
// %d: accept, BCD conversion of four bits per step, optional minus sign,
//   skip of the leading zero digits, then one output character per
//   printed digit.
// One item at a time; output stalls hold the item. Reset (rst_ni low, async): plain mode.
module format_print_engine_top #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  fmt_char_i,
  input  logic signed [ARG_WIDTH-1:0] arg_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_char_o,
  output logic                        last_o
);
  import fpe_pkg::*;

  upc_t     upc_q, upc_d;
  logic     after_q, after_d;
  ucode_t   uw;
  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     in_fire;
  logic     out_fire;
  upc_t     disp;

  assign uw = UCODE[upc_q];

  // Handshake
  assign in_stall_o = (uw.jump != J_DISPATCH);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_o && !out_stall_i;

  // Output valid and last
  always_comb begin
    case (uw.emit)
      EM_NONE:  out_valid_o = 1'b0;
      EM_MINUS: out_valid_o = stat.neg;
      default:  out_valid_o = 1'b1;
    endcase
    case (uw.last)
      LAST_YES:   last_o = 1'b1;
      LAST_DIGIT: last_o = stat.one_left;
      default:    last_o = 1'b0;
    endcase
  end

  // Specifier decode and mode update
  always_comb begin
    after_d = after_q;
    disp    = UPC_WAIT;
    if (in_fire) begin
      if (!after_q) begin
        if (fmt_char_i == CH_PERCENT) begin
          after_d = 1'b1;
        end else begin
          disp = UPC_ECHO;
        end
      end else begin
        after_d = 1'b0;
        case (fmt_char_i)
          CH_PERCENT: disp = UPC_ECHO;
          CH_LOWER_C: disp = UPC_ARGB;
          CH_LOWER_D: disp = UPC_CONV;
          default:    disp = UPC_WAIT;
        endcase
      end
    end
  end

  // Next step and gated datapath operation
  always_comb begin
    upc_d     = upc_q;
    ctrl.emit = uw.emit;
    ctrl.op   = OP_NONE;
    case (uw.jump)
      J_DISPATCH: begin
        if (in_fire) begin
          ctrl.op = uw.op;
          upc_d   = disp;
        end
      end
      J_OUT: begin
        if (out_fire) upc_d = uw.target;
      end
      J_CONV: begin
        ctrl.op = uw.op;
        if (stat.conv_done) upc_d = uw.target;
      end
      J_SIGN: begin
        if (!stat.neg || out_fire) upc_d = uw.target;
      end
      J_SKIP: begin
        if (stat.top_zero && !stat.one_left) begin
          ctrl.op = uw.op;
        end else begin
          upc_d = uw.target;
        end
      end
      J_DIGIT: begin
        if (out_fire) begin
          ctrl.op = uw.op;
          if (stat.one_left) upc_d = uw.target;
        end
      end
      default: upc_d = uw.target;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= UPC_WAIT;
      after_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      after_q <= after_d;
    end
  end

  fpe_datapath #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .fmt_char_i  (fmt_char_i),
    .arg_value_i (arg_value_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_char_o  (out_char_o)
  );

endmodule
